FILE: rtl/cgtc_pkg.sv
// Shared constants, register codes and coefficient functions for the tone curve.
`default_nettype none

package cgtc_pkg;

  localparam int CHANNELS  = 3;
  localparam int IN_WIDTH  = 24;
  localparam int OUT_WIDTH = 16;
  localparam int GAMMA_W   = 16;
  localparam int DIV_BITS  = 32;
  localparam int FRAC_BITS = 28;
  localparam int INT_W     = 6;
  localparam int LOG_W     = INT_W + FRAC_BITS;
  localparam int EXP_W     = LOG_W + GAMMA_W - 12;
  localparam int SHIFT_W   = EXP_W - FRAC_BITS;
  localparam int ACC_W     = 33;
  localparam int SHIFT_LIM = 40;

  // Stage indices of the channel datapath
  localparam int ST_NORM  = DIV_BITS + 1;
  localparam int ST_LOG   = ST_NORM + FRAC_BITS + 1;
  localparam int ST_MUL   = ST_LOG + 1;
  localparam int ST_LAST  = ST_MUL + FRAC_BITS;
  localparam int PIPE_DEPTH = ST_LAST + 2;

  localparam logic [IN_WIDTH-1:0] CLAMP_RST = 24'd65536;
  localparam logic [GAMMA_W-1:0]  GAMMA_RST = 16'd4096;

  typedef enum logic {
    REG_CLAMP = 1'b0,
    REG_GAMMA = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic sat;
    logic zer;
  } chan_flag_t;

  // Integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bit_v;
    a     = a_in;
    res   = 64'd0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > a) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (a >= res + bit_v) begin
          a   = a - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // 2^(-2^-k) in UQ0.32 by repeated square roots
  function automatic logic [31:0] exp_coef(input int k);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int i = 1; i < k; i++) begin
      c = isqrt64({c[31:0], 32'h0});
    end
    return c[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cgtc_chan.sv
// One color channel of the tone curve: divide, log2, scale, exp2, round.
`default_nettype none

module cgtc_chan import cgtc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [IN_WIDTH-1:0]  x,
  input  logic [IN_WIDTH-1:0]  v,
  input  logic [GAMMA_W-1:0]   e,
  output logic [OUT_WIDTH-1:0] y
);

  logic [IN_WIDTH-1:0]  rem_r [0:DIV_BITS];
  logic [DIV_BITS-1:0]  q_r   [0:DIV_BITS];
  chan_flag_t           flag_r [0:ST_LAST];
  logic [31:0]          lm_r  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] lf_r  [0:FRAC_BITS];
  logic [INT_W-1:0]     ip_r  [0:FRAC_BITS];
  logic [LOG_W-1:0]     lg_r;
  logic [ACC_W-1:0]     acc_r [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] fr_r  [0:FRAC_BITS];
  logic [SHIFT_W-1:0]   n_r   [0:FRAC_BITS];
  logic [OUT_WIDTH-1:0] y_r;

  // Capture the word and classify the special cases
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]      <= x;
      q_r[0]        <= '0;
      flag_r[0].sat <= (x >= v) || (e == '0);
      flag_r[0].zer <= (x == '0);
    end
  end

  // Carry the flags alongside the data
  for (genvar i = 1; i <= ST_LAST; i++) begin : g_flag
    always_ff @(posedge clk) begin
      if (en) flag_r[i] <= flag_r[i-1];
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [IN_WIDTH:0]   t;
    logic                ge;
    logic [IN_WIDTH-1:0] rem_nxt;
    always_comb begin
      t  = {rem_r[j], 1'b0};
      ge = t >= {1'b0, v};
      if (ge) begin
        rem_nxt = IN_WIDTH'(t - {1'b0, v});
      end else begin
        rem_nxt = t[IN_WIDTH-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= rem_nxt;
        q_r[j+1]   <= {q_r[j][DIV_BITS-2:0], ge};
      end
    end
  end

  // Normalize the quotient on its leading one
  logic [4:0]  lead;
  logic [31:0] lm_nxt;
  logic [INT_W-1:0] ip_nxt;
  always_comb begin
    lead = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      if (q_r[DIV_BITS][i]) lead = 5'(i);
    end
    lm_nxt = q_r[DIV_BITS] << (5'd31 - lead);
    ip_nxt = 6'd32 - {1'b0, lead};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lm_r[0] <= lm_nxt;
      lf_r[0] <= '0;
      ip_r[0] <= ip_nxt;
    end
  end

  // Log2 fraction, one squaring per stage
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_log
    logic [63:0] sq;
    logic [32:0] sh;
    always_comb begin
      sq = lm_r[j] * lm_r[j];
      sh = sq[63:31];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lm_r[j+1] <= sh[32] ? sh[32:1] : sh[31:0];
        lf_r[j+1] <= {lf_r[j][FRAC_BITS-2:0], sh[32]};
        ip_r[j+1] <= ip_r[j];
      end
    end
  end

  // Form -log2 of the ratio
  always_ff @(posedge clk) begin
    if (en) lg_r <= {ip_r[FRAC_BITS], {FRAC_BITS{1'b0}}} - {{INT_W{1'b0}}, lf_r[FRAC_BITS]};
  end

  // Scale by the exponent
  logic [LOG_W+GAMMA_W-1:0] prod;
  assign prod = lg_r * e;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r[0] <= {1'b1, 32'h0};
      fr_r[0]  <= prod[FRAC_BITS+11:12];
      n_r[0]   <= prod[LOG_W+GAMMA_W-1:FRAC_BITS+12];
    end
  end

  // Exp2 of the fraction, one constant factor per stage
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_exp
    localparam logic [31:0] COEF = exp_coef(j + 1);
    logic [ACC_W+31:0] mp;
    assign mp = acc_r[j] * COEF;
    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[j+1] <= fr_r[j][FRAC_BITS-1-j] ? mp[ACC_W+31:32] : acc_r[j];
        fr_r[j+1]  <= fr_r[j];
        n_r[j+1]   <= n_r[j];
      end
    end
  end

  // Shift by the integer part, round, saturate
  logic [ACC_W-1:0] shd;
  logic [ACC_W:0]   rnd;
  logic [OUT_WIDTH-1:0] y_nxt;
  always_comb begin
    if (n_r[FRAC_BITS] >= SHIFT_W'(SHIFT_LIM)) begin
      shd = '0;
    end else begin
      shd = acc_r[FRAC_BITS] >> n_r[FRAC_BITS];
    end
    rnd = {1'b0, shd} + (ACC_W+1)'(1 << (31 - OUT_WIDTH));
    if (flag_r[ST_LAST].sat) begin
      y_nxt = '1;
    end else if (flag_r[ST_LAST].zer) begin
      y_nxt = '0;
    end else if (rnd[ACC_W:32] != '0) begin
      y_nxt = '1;
    end else begin
      y_nxt = rnd[31:32-OUT_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) y_r <= y_nxt;
  end

  assign y = y_r;

endmodule

`default_nettype wire

FILE: rtl/clamp_gamma_tone_curve.sv
// Top level: register port, pixel pipeline control and three channel datapaths.
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  in_      | in_valid/in_ready  | red, green, blue (UQ8.16), last_pixel
//  out_     | out_valid/out_ready| red, green, blue (UQ0.16), last_pixel
//  cfg_     | APB, pready high   | 0x0 clamp_level, 0x4 inverse_gamma
//
// One pixel per clock unless the output stalls; the pipeline holds the 32-step divider,
// 28 log2 squaring stages and 28 exp2 multiply stages.
// Synchronous active-low reset clears valid bits and loads the register defaults.
// An output stall freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module clamp_gamma_tone_curve import cgtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_WIDTH-1:0]  in_red,
  input  logic [IN_WIDTH-1:0]  in_green,
  input  logic [IN_WIDTH-1:0]  in_blue,
  input  logic                 in_last_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_WIDTH-1:0] out_red,
  output logic [OUT_WIDTH-1:0] out_green,
  output logic [OUT_WIDTH-1:0] out_blue,
  output logic                 out_last_pixel,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  logic [IN_WIDTH-1:0] clamp_r;
  logic [GAMMA_W-1:0]  gamma_r;
  reg_idx_t            widx;
  logic                wr_en;

  // Register file
  assign cfg_pready = 1'b1;
  assign widx  = reg_idx_t'(cfg_paddr[2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_r <= CLAMP_RST;
      gamma_r <= GAMMA_RST;
    end else if (wr_en) begin
      case (widx)
        REG_CLAMP: clamp_r <= cfg_pwdata[IN_WIDTH-1:0];
        REG_GAMMA: gamma_r <= cfg_pwdata[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_CLAMP: cfg_prdata = {{(32-IN_WIDTH){1'b0}}, clamp_r};
      REG_GAMMA: cfg_prdata = {{(32-GAMMA_W){1'b0}}, gamma_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Advance the pipeline unless the output word is held
  logic vld_r  [0:PIPE_DEPTH-1];
  logic last_r [0:PIPE_DEPTH-1];
  logic en;

  assign en       = !vld_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) last_r[0] <= in_last_pixel;
  end

  for (genvar i = 1; i < PIPE_DEPTH; i++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) last_r[i] <= last_r[i-1];
    end
  end

  // Channel datapaths
  cgtc_chan u_red (
    .clk (clk), .en (en), .x (in_red),   .v (clamp_r), .e (gamma_r), .y (out_red)
  );
  cgtc_chan u_green (
    .clk (clk), .en (en), .x (in_green), .v (clamp_r), .e (gamma_r), .y (out_green)
  );
  cgtc_chan u_blue (
    .clk (clk), .en (en), .x (in_blue),  .v (clamp_r), .e (gamma_r), .y (out_blue)
  );

  assign out_valid      = vld_r[PIPE_DEPTH-1];
  assign out_last_pixel = last_r[PIPE_DEPTH-1];

endmodule

`default_nettype wire
